// ===== hw/rtl/mss_pkg.sv =====
// Package for the motor start safety sequencer: codes, item types and helpers.
// Depends on nothing; used by every module in hw/rtl.
package mss_pkg;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_ARMED  = 3'd1;
   localparam logic [2:0] PH_ENWAIT = 3'd2;
   localparam logic [2:0] PH_RUN    = 3'd3;
   localparam logic [2:0] PH_HOLD   = 3'd4;
   localparam logic [2:0] PH_FZERO  = 3'd5;
   localparam logic [2:0] PH_FDIS   = 3'd6;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_TXF   = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_ENABLE  = 3'd1;
   localparam logic [2:0] ACT_POS_VEL = 3'd2;
   localparam logic [2:0] ACT_ZERO    = 3'd3;
   localparam logic [2:0] ACT_DISABLE = 3'd4;

   localparam logic [3:0] EV_NONE     = 4'd0;
   localparam logic [3:0] EV_STATUS   = 4'd1;
   localparam logic [3:0] EV_REJECT   = 4'd2;
   localparam logic [3:0] EV_ARMED    = 4'd3;
   localparam logic [3:0] EV_ARM_TO   = 4'd4;
   localparam logic [3:0] EV_START    = 4'd5;
   localparam logic [3:0] EV_ESTOP    = 4'd6;
   localparam logic [3:0] EV_TRIP     = 4'd7;
   localparam logic [3:0] EV_RUNNING  = 4'd8;
   localparam logic [3:0] EV_HOLD     = 4'd9;
   localparam logic [3:0] EV_COMPLETE = 4'd10;
   localparam logic [3:0] EV_TXF      = 4'd11;

   localparam logic [4:0] RS_NONE       = 5'd0;
   localparam logic [4:0] RS_IGNORED    = 5'd1;
   localparam logic [4:0] RS_UNKNOWN    = 5'd2;
   localparam logic [4:0] RS_MOTION     = 5'd3;
   localparam logic [4:0] RS_ARM_TO     = 5'd4;
   localparam logic [4:0] RS_ARM_FIRST  = 5'd5;
   localparam logic [4:0] RS_PARAMS     = 5'd6;
   localparam logic [4:0] RS_MODE       = 5'd7;
   localparam logic [4:0] RS_STALE      = 5'd8;
   localparam logic [4:0] RS_NOT_DIS    = 5'd9;
   localparam logic [4:0] RS_SPEED_NZ   = 5'd10;
   localparam logic [4:0] RS_TEMP       = 5'd11;
   localparam logic [4:0] RS_BUS        = 5'd12;
   localparam logic [4:0] RS_ESTOP      = 5'd13;
   localparam logic [4:0] RS_SPEED_LIM  = 5'd14;
   localparam logic [4:0] RS_NOT_EN     = 5'd15;
   localparam logic [4:0] RS_FAULT_STOP = 5'd16;
   localparam logic [4:0] RS_INVALID    = 5'd17;
   localparam logic [4:0] RS_TXF        = 5'd18;

   localparam logic [2:0] REG_ARM_WINDOW = 3'd0;
   localparam logic [2:0] REG_EN_WAIT    = 3'd1;
   localparam logic [2:0] REG_RUN_TIME   = 3'd2;
   localparam logic [2:0] REG_ZERO_HOLD  = 3'd3;
   localparam logic [2:0] REG_REFRESH    = 3'd4;
   localparam logic [2:0] REG_START_LIM  = 3'd5;
   localparam logic [2:0] REG_RUN_LIM    = 3'd6;
   localparam logic [2:0] REG_TEMP_LIM   = 3'd7;

   // Decoded command classes produced by the front end.
   localparam logic [2:0] CMD_BLANK   = 3'd0;
   localparam logic [2:0] CMD_STATUS  = 3'd1;
   localparam logic [2:0] CMD_ARM     = 3'd2;
   localparam logic [2:0] CMD_GO      = 3'd3;
   localparam logic [2:0] CMD_STOP    = 3'd4;
   localparam logic [2:0] CMD_UNKNOWN = 3'd5;

   // Command characters; lower case letters are folded by clearing the case bit.
   localparam logic [7:0] CHR_CR      = 8'h0d;
   localparam logic [7:0] CHR_LF      = 8'h0a;
   localparam logic [7:0] CHR_S       = 8'h53;
   localparam logic [7:0] CHR_A       = 8'h41;
   localparam logic [7:0] CHR_G       = 8'h47;
   localparam logic [7:0] CHR_X       = 8'h58;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHR_CASE    = 8'h20;

   localparam logic [7:0] PARAMS_COMPLETE = 8'h1f;
   localparam logic [7:0] MODE_VELOCITY   = 8'd3;
   localparam logic [7:0] MOTOR_DISABLED  = 8'd0;
   localparam logic [7:0] MOTOR_ENABLED   = 8'd1;

   localparam logic [15:0] START_MAX_AGE = 16'd500;
   localparam logic [15:0] RUN_MAX_AGE   = 16'd100;

   typedef struct packed {
      logic [31:0] arm_window;
      logic [31:0] en_wait;
      logic [31:0] run_time;
      logic [31:0] zero_hold;
      logic [15:0] refresh;
      logic [14:0] start_lim;
      logic [14:0] run_lim;
      logic [7:0]  temp_lim;
   } cfg_type;

   // Classified item: time plus safety check results already evaluated.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  cmd;
      logic [31:0] now;
      logic [4:0]  start_rs;
      logic [4:0]  wait_rs;
      logic        stale;
      logic        bus_bad;
      logic        motor_en;
      logic        motor_dis;
   } item_type;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] event_res;
      logic [4:0] reason;
      logic [2:0] phase_out;
   } rsp_type;

endpackage

// ===== hw/rtl/mss_front.sv =====
// Front end: takes request items, decodes the command and runs the safety checks.
// Depends on mss_pkg.
module mss_front (
   input  logic                 clock,
   input  logic                 reset,
   input  mss_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           kind,
   input  logic [7:0]           command_byte,
   input  logic [31:0]          now_ms,
   input  logic [7:0]           param_mask,
   input  logic [7:0]           ctrl_mode,
   input  logic                 fb_ok,
   input  logic [15:0]          fb_age,
   input  logic [7:0]           motor_report,
   input  logic signed [15:0]   velocity,
   input  logic [7:0]           driver_temp,
   input  logic [7:0]           rotor_temp,
   input  logic [2:0]           bus_flags,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mss_pkg::item_type    out_item
);

   logic              valid_ff, valid_in;
   mss_pkg::item_type item_ff, item_in;
   logic [7:0]        cf;
   logic [16:0]       vel_abs;
   logic              hot, stale_s, stale_r;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      cf = command_byte;
      if (command_byte >= mss_pkg::CHR_LOWER_A && command_byte <= mss_pkg::CHR_LOWER_Z) begin
         cf = command_byte - mss_pkg::CHR_CASE;
      end
      vel_abs = velocity[15] ? (17'd0 - {velocity[15], velocity}) : {1'b0, velocity};
      hot = (driver_temp >= cfg.temp_lim) || (rotor_temp >= cfg.temp_lim);
      stale_s = !fb_ok || (fb_age > mss_pkg::START_MAX_AGE);
      stale_r = !fb_ok || (fb_age > mss_pkg::RUN_MAX_AGE);

      item_in.kind = kind;
      item_in.now  = now_ms;
      unique case (cf)
         mss_pkg::CHR_CR, mss_pkg::CHR_LF: item_in.cmd = mss_pkg::CMD_BLANK;
         mss_pkg::CHR_S: item_in.cmd = mss_pkg::CMD_STATUS;
         mss_pkg::CHR_A: item_in.cmd = mss_pkg::CMD_ARM;
         mss_pkg::CHR_G: item_in.cmd = mss_pkg::CMD_GO;
         mss_pkg::CHR_X: item_in.cmd = mss_pkg::CMD_STOP;
         default:        item_in.cmd = mss_pkg::CMD_UNKNOWN;
      endcase

      priority if (param_mask != mss_pkg::PARAMS_COMPLETE) item_in.start_rs = mss_pkg::RS_PARAMS;
      else if (ctrl_mode != mss_pkg::MODE_VELOCITY) item_in.start_rs = mss_pkg::RS_MODE;
      else if (stale_s)                 item_in.start_rs = mss_pkg::RS_STALE;
      else if (motor_report != mss_pkg::MOTOR_DISABLED) item_in.start_rs = mss_pkg::RS_NOT_DIS;
      else if (vel_abs >= {2'b0, cfg.start_lim}) item_in.start_rs = mss_pkg::RS_SPEED_NZ;
      else if (hot)                     item_in.start_rs = mss_pkg::RS_TEMP;
      else if (bus_flags != 3'd0)       item_in.start_rs = mss_pkg::RS_BUS;
      else                              item_in.start_rs = mss_pkg::RS_NONE;

      priority if (stale_r)             item_in.wait_rs = mss_pkg::RS_STALE;
      else if (vel_abs > {2'b0, cfg.run_lim}) item_in.wait_rs = mss_pkg::RS_SPEED_LIM;
      else if (hot)                     item_in.wait_rs = mss_pkg::RS_TEMP;
      else if (bus_flags[2:1] != 2'd0)  item_in.wait_rs = mss_pkg::RS_BUS;
      else                              item_in.wait_rs = mss_pkg::RS_NONE;

      item_in.stale     = stale_r;
      item_in.bus_bad   = bus_flags[2:1] != 2'd0;
      item_in.motor_en  = motor_report == mss_pkg::MOTOR_ENABLED;
      item_in.motor_dis = motor_report == mss_pkg::MOTOR_DISABLED;

      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hw/rtl/mss_queue.sv =====
// Two-entry queue between the front end and the sequencer back end.
// Depends on mss_pkg.
module mss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mss_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output mss_pkg::item_type out_item
);

   mss_pkg::item_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
   end

endmodule

// ===== hw/rtl/mss_back.sv =====
// Back end: the phase sequencer with its timestamps and the response register.
// Depends on mss_pkg.
module mss_back (
   input  logic              clock,
   input  logic              reset,
   input  mss_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  mss_pkg::item_type it,
   output logic              out_valid,
   input  logic              out_ready,
   output mss_pkg::rsp_type  out_rsp
);

   logic [2:0]  phase_ff, phase_in;
   logic        armed_ff, armed_in;
   logic [31:0] arm_t_ff, arm_t_in, ps_t_ff, ps_t_in, la_t_ff, la_t_in;
   logic        valid_ff, valid_in;
   mss_pkg::rsp_type rsp_ff, rsp_in;
   logic        take;
   logic [31:0] d_arm, d_ps, d_la;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;
   assign take      = in_valid && in_ready;

   always_comb begin
      logic [2:0] a;
      logic [3:0] e;
      logic [4:0] r;
      logic       fs;
      logic [31:0] fs_t;
      logic [3:0] fs_e;
      logic [4:0] fs_r;
      d_arm = it.now - arm_t_ff;
      d_ps  = it.now - ps_t_ff;
      d_la  = it.now - la_t_ff;
      phase_in = phase_ff;
      armed_in = armed_ff;
      arm_t_in = arm_t_ff;
      ps_t_in  = ps_t_ff;
      la_t_in  = la_t_ff;
      a = mss_pkg::ACT_NONE;
      e = mss_pkg::EV_NONE;
      r = mss_pkg::RS_NONE;
      fs = 1'b0;
      fs_t = it.now;
      fs_e = mss_pkg::EV_TRIP;
      fs_r = mss_pkg::RS_NONE;
      unique case (it.kind)
         mss_pkg::KIND_TICK: begin
            unique case (phase_ff)
               mss_pkg::PH_IDLE: begin
               end
               mss_pkg::PH_ARMED: begin
                  if (d_arm >= cfg.arm_window) begin
                     armed_in = 1'b0;
                     phase_in = mss_pkg::PH_IDLE;
                     e = mss_pkg::EV_ARM_TO;
                     r = mss_pkg::RS_ARM_TO;
                  end
               end
               mss_pkg::PH_ENWAIT: begin
                  priority if (it.stale && it.bus_bad) begin
                     fs = 1'b1; fs_r = mss_pkg::RS_BUS;
                  end else if (!it.stale && it.wait_rs != mss_pkg::RS_NONE) begin
                     fs = 1'b1; fs_r = it.wait_rs;
                  end else if (!it.stale && it.motor_en && d_ps <= cfg.en_wait) begin
                     phase_in = mss_pkg::PH_RUN;
                     ps_t_in = it.now;
                     la_t_in = it.now;
                     a = mss_pkg::ACT_POS_VEL;
                     e = mss_pkg::EV_RUNNING;
                  end else if (!it.stale && !it.motor_dis) begin
                     fs = 1'b1; fs_r = mss_pkg::RS_NOT_EN;
                  end else if (d_ps >= cfg.en_wait) begin
                     fs = 1'b1;
                     fs_r = it.stale ? mss_pkg::RS_STALE : mss_pkg::RS_NOT_EN;
                  end else begin
                  end
               end
               mss_pkg::PH_RUN, mss_pkg::PH_HOLD: begin
                  priority if (it.wait_rs != mss_pkg::RS_NONE) begin
                     fs = 1'b1; fs_r = it.wait_rs;
                  end else if (!it.motor_en) begin
                     fs = 1'b1; fs_r = mss_pkg::RS_NOT_EN;
                  end else if (phase_ff == mss_pkg::PH_RUN && d_ps >= cfg.run_time) begin
                     phase_in = mss_pkg::PH_HOLD;
                     ps_t_in = it.now;
                     la_t_in = it.now;
                     a = mss_pkg::ACT_ZERO;
                     e = mss_pkg::EV_HOLD;
                  end else if (phase_ff == mss_pkg::PH_HOLD && d_ps >= cfg.zero_hold) begin
                     phase_in = mss_pkg::PH_IDLE;
                     la_t_in = it.now;
                     a = mss_pkg::ACT_DISABLE;
                     e = mss_pkg::EV_COMPLETE;
                  end else if (d_la >= {16'd0, cfg.refresh}) begin
                     la_t_in = it.now;
                     a = (phase_ff == mss_pkg::PH_RUN) ? mss_pkg::ACT_POS_VEL
                                                       : mss_pkg::ACT_ZERO;
                  end else begin
                  end
               end
               mss_pkg::PH_FZERO: begin
                  phase_in = mss_pkg::PH_FDIS;
                  la_t_in = it.now;
                  a = mss_pkg::ACT_ZERO;
                  e = mss_pkg::EV_TRIP;
                  r = mss_pkg::RS_FAULT_STOP;
               end
               mss_pkg::PH_FDIS: begin
                  if (d_la != 32'd0) begin
                     phase_in = mss_pkg::PH_IDLE;
                     a = mss_pkg::ACT_DISABLE;
                  end
               end
               default: begin
                  phase_in = mss_pkg::PH_IDLE;
                  armed_in = 1'b0;
                  arm_t_in = 32'd0;
                  ps_t_in = 32'd0;
                  la_t_in = 32'd0;
                  r = mss_pkg::RS_INVALID;
               end
            endcase
         end
         mss_pkg::KIND_CMD: begin
            unique case (it.cmd)
               mss_pkg::CMD_BLANK: r = mss_pkg::RS_IGNORED;
               mss_pkg::CMD_STATUS: e = mss_pkg::EV_STATUS;
               mss_pkg::CMD_ARM: begin
                  if (phase_ff != mss_pkg::PH_IDLE && phase_ff != mss_pkg::PH_ARMED) begin
                     e = mss_pkg::EV_REJECT;
                     r = mss_pkg::RS_MOTION;
                  end else begin
                     phase_in = mss_pkg::PH_ARMED;
                     armed_in = 1'b1;
                     arm_t_in = it.now;
                     e = mss_pkg::EV_ARMED;
                  end
               end
               mss_pkg::CMD_GO: begin
                  priority if (armed_ff && d_arm >= cfg.arm_window) begin
                     armed_in = 1'b0;
                     phase_in = mss_pkg::PH_IDLE;
                     e = mss_pkg::EV_ARM_TO;
                     r = mss_pkg::RS_ARM_TO;
                  end else if (!armed_ff || phase_ff != mss_pkg::PH_ARMED) begin
                     e = mss_pkg::EV_REJECT;
                     r = mss_pkg::RS_ARM_FIRST;
                  end else if (it.start_rs != mss_pkg::RS_NONE) begin
                     e = mss_pkg::EV_REJECT;
                     r = it.start_rs;
                  end else begin
                     armed_in = 1'b0;
                     phase_in = mss_pkg::PH_ENWAIT;
                     ps_t_in = it.now;
                     la_t_in = it.now;
                     a = mss_pkg::ACT_ENABLE;
                     e = mss_pkg::EV_START;
                  end
               end
               mss_pkg::CMD_STOP: begin
                  fs = 1'b1; fs_e = mss_pkg::EV_ESTOP; fs_r = mss_pkg::RS_ESTOP;
               end
               default: r = mss_pkg::RS_UNKNOWN;
            endcase
         end
         mss_pkg::KIND_TXF: begin
            if (phase_ff == mss_pkg::PH_FDIS) begin
               phase_in = mss_pkg::PH_IDLE;
               armed_in = 1'b0;
               a = mss_pkg::ACT_DISABLE;
               e = mss_pkg::EV_TXF;
               r = mss_pkg::RS_TXF;
            end else begin
               fs = 1'b1; fs_t = la_t_ff; fs_e = mss_pkg::EV_TXF; fs_r = mss_pkg::RS_TXF;
            end
         end
         default: r = mss_pkg::RS_IGNORED;
      endcase
      if (fs) begin
         armed_in = 1'b0;
         ps_t_in = fs_t;
         la_t_in = fs_t;
         phase_in = mss_pkg::PH_FDIS;
         a = mss_pkg::ACT_ZERO;
         e = fs_e;
         r = fs_r;
      end
      rsp_in.action = a;
      rsp_in.event_res = e;
      rsp_in.reason = r;
      rsp_in.phase_out = phase_in;
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mss_pkg::PH_IDLE;
         armed_ff <= 1'b0;
         arm_t_ff <= 32'd0;
         ps_t_ff  <= 32'd0;
         la_t_ff  <= 32'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            phase_ff <= phase_in;
            armed_ff <= armed_in;
            arm_t_ff <= arm_t_in;
            ps_t_ff  <= ps_t_in;
            la_t_ff  <= la_t_in;
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== hw/rtl/motor_start_safety_sequencer.sv =====
// Motor start safety sequencer top level: front end, queue, back end, registers.
// A request passes through the front register, a queue entry and the response register,
// in that order, before its response is presented.
// Throughput: one request per cycle when the response side does not stall.
// Reset is synchronous and active high; it clears the phase, arm flag, timestamps,
// queue and valid flags and loads the register defaults. Depends on all hw/rtl modules.
module motor_start_safety_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   // command_byte[7:0], now_ms[39:8], param_mask[47:40], ctrl_mode[55:48],
   // fb_ok[56], fb_age[72:57], motor_report[80:73],
   // velocity[96:81], driver_temp[104:97], rotor_temp[112:105], bus_flags[115:113]
   input  logic [119:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // action[2:0], event_res[6:3], reason[11:7], phase_out[14:12]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   mss_pkg::cfg_type  cfg_ff, cfg_in;
   mss_pkg::item_type f_item, q_item;
   mss_pkg::rsp_type  rsp;
   logic f_valid, f_ready, q_valid, q_ready;

   // Configuration registers, written directly by the register port.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mss_pkg::REG_ARM_WINDOW: cfg_in.arm_window = csr_wdata;
            mss_pkg::REG_EN_WAIT:    cfg_in.en_wait = csr_wdata;
            mss_pkg::REG_RUN_TIME:   cfg_in.run_time = csr_wdata;
            mss_pkg::REG_ZERO_HOLD:  cfg_in.zero_hold = csr_wdata;
            mss_pkg::REG_REFRESH:    cfg_in.refresh = csr_wdata[15:0];
            mss_pkg::REG_START_LIM:  cfg_in.start_lim = csr_wdata[14:0];
            mss_pkg::REG_RUN_LIM:    cfg_in.run_lim = csr_wdata[14:0];
            default:                 cfg_in.temp_lim = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_window <= 32'd10000;
         cfg_ff.en_wait    <= 32'd100;
         cfg_ff.run_time   <= 32'd1000;
         cfg_ff.zero_hold  <= 32'd200;
         cfg_ff.refresh    <= 16'd10;
         cfg_ff.start_lim  <= 15'd100;
         cfg_ff.run_lim    <= 15'd800;
         cfg_ff.temp_lim   <= 8'd60;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end decodes each request and evaluates its checks in parallel.
   mss_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .kind(req_tuser), .command_byte(req_tdata[7:0]), .now_ms(req_tdata[39:8]),
      .param_mask(req_tdata[47:40]), .ctrl_mode(req_tdata[55:48]),
      .fb_ok(req_tdata[56]), .fb_age(req_tdata[72:57]),
      .motor_report(req_tdata[80:73]), .velocity(req_tdata[96:81]),
      .driver_temp(req_tdata[104:97]), .rotor_temp(req_tdata[112:105]),
      .bus_flags(req_tdata[115:113]),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   // The queue lets the front end keep taking requests while the response side stalls.
   mss_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   // The back end owns all sequencing state and registers each response.
   mss_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(q_valid), .in_ready(q_ready), .it(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tdata = {1'b0, rsp.phase_out, rsp.reason, rsp.event_res, rsp.action};

`ifndef SYNTHESIS
   // A response never reports the unused phase code.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.phase_out != 3'd7) else $error("bad phase_out");
   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp changed");
   // An enable action only comes with the start requested event.
   a_enable_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.action == mss_pkg::ACT_ENABLE |-> rsp.event_res == mss_pkg::EV_START)
      else $error("enable without start");
`endif

endmodule
